[hdl/dfpc_pkg.sv]
// shared types and constants for the dark and flat pixel calibration block
package dfpc_pkg;

    localparam int PIX_BITS      = 16;
    localparam int CHANNEL_COUNT = 3;
    localparam int MEAN_REGS     = 3;
    localparam int CH_BITS       = 2;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [PIX_BITS-1:0] PIX_MAX = {PIX_BITS{1'b1}};

    // highest channel that owns a mean register
    localparam int CH_TOP_INT = ((CHANNEL_COUNT < MEAN_REGS) ? CHANNEL_COUNT : MEAN_REGS) - 1;
    localparam logic [CH_BITS-1:0] CH_TOP = CH_BITS'(CH_TOP_INT);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_APPLY_DARK      = 3'd0,
        CFG_APPLY_FLAT      = 3'd1,
        CFG_FLAT_MEAN_RED   = 3'd2,
        CFG_FLAT_MEAN_GREEN = 3'd3,
        CFG_FLAT_MEAN_BLUE  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CH_BITS-1:0]  channel_index;
        logic [PIX_BITS-1:0] light_pixel;
        logic [PIX_BITS-1:0] dark_pixel;
        logic [PIX_BITS-1:0] flat_pixel;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] calibrated_pixel;
        logic                was_clipped;
    } pix_out_t;

    // one slot of the divider pipeline
    typedef struct packed {
        logic [PIX_BITS-1:0] rem;
        logic [PIX_BITS-1:0] lo;
        logic [PIX_BITS-1:0] flat;
        logic                done;
        logic [PIX_BITS-1:0] res;
        logic                clip;
    } div_t;

endpackage

[hdl/dfpc_div_step.sv]
// one restoring division step: brings in one dividend bit, yields one quotient bit
module dfpc_div_step
    import dfpc_pkg::*;
(
    input  div_t slot_in,
    output div_t slot_out
);

    logic [PIX_BITS:0] shifted;
    logic [PIX_BITS:0] diff;
    logic              ge;

    always_comb
    begin
        shifted = {slot_in.rem, slot_in.lo[PIX_BITS-1]};
        diff    = shifted - {1'b0, slot_in.flat};
        ge      = (shifted >= {1'b0, slot_in.flat});

        slot_out      = slot_in;
        // remainder stays below the divisor, so it fits the pixel width
        slot_out.rem  = ge ? diff[PIX_BITS-1:0] : shifted[PIX_BITS-1:0];
        slot_out.lo   = {slot_in.lo[PIX_BITS-2:0], ge};
    end

endmodule

[hdl/dark_flat_pixel_calibration.sv]
// top level: dark subtraction and flat field correction pipeline
//
//  port group   direction  handshake            payload
//  in           into block in_valid / in_stall  in_data  (pix_in_t)
//  out          from block out_valid / out_stall out_data (pix_out_t)
//  cfg          into block cfg_we               cfg_index, cfg_data
//
// one pixel enters per clock while in_stall is low; the stages are: operand stage, multiply,
// rounding add with overflow check, 16 quotient bit stages, output register.
// the divider is fully pipelined, one single-bit stage per quotient bit.
// each stage has its own valid bit and advances when the next one is empty or moving,
// so bubbles close up under a stall and in_stall rises only with the whole pipe full.
// rst_n clears valid bits and apply flags and sets the mean registers to PIX_MAX; no clearing pass is needed.
module dark_flat_pixel_calibration
    import dfpc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  pix_in_t                 in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output pix_out_t                out_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [PIX_BITS-1:0]     cfg_data
);

    // configuration registers
    logic                apply_dark_reg;
    logic                apply_flat_reg;
    logic [PIX_BITS-1:0] mean_reg [MEAN_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apply_dark_reg <= 1'b0;
            apply_flat_reg <= 1'b0;
            for (int i = 0; i < MEAN_REGS; i++)
            begin
                mean_reg[i] <= PIX_MAX;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_APPLY_DARK:      apply_dark_reg <= cfg_data[0];
                CFG_APPLY_FLAT:      apply_flat_reg <= cfg_data[0];
                CFG_FLAT_MEAN_RED:   mean_reg[0]    <= cfg_data;
                CFG_FLAT_MEAN_GREEN: mean_reg[1]    <= cfg_data;
                CFG_FLAT_MEAN_BLUE:  mean_reg[2]    <= cfg_data;
                default:             ;
            endcase
        end
    end

    // pipeline flow control
    logic              a_v_reg;
    logic              b_v_reg;
    logic [PIX_BITS:0] div_v_reg;
    logic              out_v_reg;

    logic              out_rdy;
    logic [PIX_BITS:0] div_rdy;
    logic              b_rdy;
    logic              a_rdy;

    assign out_rdy          = !out_v_reg || !out_stall;
    assign div_rdy[PIX_BITS] = !div_v_reg[PIX_BITS] || out_rdy;

    genvar g;
    generate
        for (g = 0; g < PIX_BITS; g++)
        begin : g_rdy
            assign div_rdy[g] = !div_v_reg[g] || div_rdy[g+1];
        end
    endgenerate

    assign b_rdy    = !b_v_reg || div_rdy[0];
    assign a_rdy    = !a_v_reg || b_rdy;
    assign in_stall = !a_rdy;

    // stage a: dark subtraction, special cases, mean select
    logic [PIX_BITS:0]   num_next;
    logic [CH_BITS-1:0]  ch_sel;
    logic [PIX_BITS-1:0] mean_next;
    logic                done_next;
    logic [PIX_BITS-1:0] res_next;
    logic                clip_next;
    logic                num_neg;
    logic                num_zero;

    always_comb
    begin
        num_next = {1'b0, in_data.light_pixel};
        if (apply_dark_reg)
        begin
            num_next = {1'b0, in_data.light_pixel} - {1'b0, in_data.dark_pixel};
        end
        num_neg  = num_next[PIX_BITS];
        num_zero = (num_next == '0);

        ch_sel    = (in_data.channel_index > CH_TOP) ? CH_TOP : in_data.channel_index;
        mean_next = mean_reg[ch_sel];

        done_next = 1'b1;
        res_next  = '0;
        clip_next = 1'b0;
        if (num_neg)
        begin
            clip_next = 1'b1;
        end
        else if (!apply_flat_reg)
        begin
            res_next = num_next[PIX_BITS-1:0];
        end
        else if (num_zero)
        begin
            res_next = '0;
        end
        else if (in_data.flat_pixel == '0)
        begin
            res_next  = PIX_MAX;
            clip_next = 1'b1;
        end
        else
        begin
            done_next = 1'b0;
        end
    end

    logic [PIX_BITS-1:0] a_num_reg;
    logic [PIX_BITS-1:0] a_mean_reg;
    logic [PIX_BITS-1:0] a_flat_reg;
    logic                a_done_reg;
    logic [PIX_BITS-1:0] a_res_reg;
    logic                a_clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (a_rdy)
        begin
            a_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && in_valid)
        begin
            a_num_reg  <= num_next[PIX_BITS-1:0];
            a_mean_reg <= mean_next;
            a_flat_reg <= in_data.flat_pixel;
            a_done_reg <= done_next;
            a_res_reg  <= res_next;
            a_clip_reg <= clip_next;
        end
    end

    // stage b: numerator times channel mean
    logic [2*PIX_BITS-1:0] b_prod_reg;
    logic [PIX_BITS-1:0]   b_flat_reg;
    logic                  b_done_reg;
    logic [PIX_BITS-1:0]   b_res_reg;
    logic                  b_clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (b_rdy)
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_rdy && a_v_reg)
        begin
            b_prod_reg <= a_num_reg * a_mean_reg;
            b_flat_reg <= a_flat_reg;
            b_done_reg <= a_done_reg;
            b_res_reg  <= a_res_reg;
            b_clip_reg <= a_clip_reg;
        end
    end

    // stage c: add half the divisor for rounding, catch quotient overflow
    logic [2*PIX_BITS-1:0] dividend;
    logic                  ovf;
    div_t                  c_next;
    div_t                  div_reg [PIX_BITS+1];

    always_comb
    begin
        // max product plus half divisor stays below 2^(2*PIX_BITS)
        dividend = b_prod_reg + {{PIX_BITS{1'b0}}, 1'b0, b_flat_reg[PIX_BITS-1:1]};
        ovf      = (dividend[2*PIX_BITS-1:PIX_BITS] >= b_flat_reg);

        c_next.rem  = dividend[2*PIX_BITS-1:PIX_BITS];
        c_next.lo   = dividend[PIX_BITS-1:0];
        c_next.flat = b_flat_reg;
        c_next.done = b_done_reg || ovf;
        c_next.res  = b_done_reg ? b_res_reg : PIX_MAX;
        c_next.clip = b_done_reg ? b_clip_reg : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_v_reg[0] <= 1'b0;
        end
        else if (div_rdy[0])
        begin
            div_v_reg[0] <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_rdy[0] && b_v_reg)
        begin
            div_reg[0] <= c_next;
        end
    end

    // quotient bit stages, most significant bit first
    generate
        for (g = 1; g <= PIX_BITS; g++)
        begin : g_div
            div_t step_next;

            dfpc_div_step u_step
            (
                .slot_in  (div_reg[g-1]),
                .slot_out (step_next)
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    div_v_reg[g] <= 1'b0;
                end
                else if (div_rdy[g])
                begin
                    div_v_reg[g] <= div_v_reg[g-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (div_rdy[g] && div_v_reg[g-1])
                begin
                    div_reg[g] <= step_next;
                end
            end
        end
    endgenerate

    // output register
    pix_out_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_rdy)
        begin
            out_v_reg <= div_v_reg[PIX_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && div_v_reg[PIX_BITS])
        begin
            out_data_reg.calibrated_pixel <= div_reg[PIX_BITS].done ?
                                             div_reg[PIX_BITS].res : div_reg[PIX_BITS].lo;
            out_data_reg.was_clipped      <= div_reg[PIX_BITS].done ?
                                             div_reg[PIX_BITS].clip : 1'b0;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_data_reg;

endmodule

[hdl/dfpc_checker.sv]
// port-level checks for the calibration block and their binding
module dfpc_checker
    import dfpc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input pix_out_t out_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // clipped results sit at one of the two rails
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.was_clipped |->
            (out_data.calibrated_pixel == '0) || (out_data.calibrated_pixel == PIX_MAX))
        else $error("clip flag on a value inside the range");

    // input backpressure only comes from a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a free output lets the pipe move, so the input must be open
    a_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled with output open");

endmodule

bind dark_flat_pixel_calibration dfpc_checker u_dfpc_checker (.*);
